>>> design/potc_pkg.sv
`timescale 1ns / 1ps
package potc_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned DIFF_W       = COORD_W + 1;
  localparam int unsigned PROD_W       = 2 * DIFF_W;
  localparam int unsigned CROSS_W      = PROD_W + 1;
  // Vertex counter saturates at MAX_VERTICES + 1.
  localparam int unsigned CNT_W        = $clog2(MAX_VERTICES + 2);
  // Balance lies within +/- MAX_VERTICES.
  localparam int unsigned BAL_W        = $clog2(MAX_VERTICES + 1) + 1;
  localparam int unsigned NUM_LANES    = 3;
  localparam int unsigned IN_DATA_W    = ((2 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W   = 8;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [1:0]         sign_t;

  localparam sign_t SIGN_NEG  = 2'sb11;
  localparam sign_t SIGN_ZERO = 2'sb00;
  localparam sign_t SIGN_POS  = 2'sb01;

  typedef enum logic [1:0] {
    ORIENT_DEGEN    = 2'd0,
    ORIENT_CW       = 2'd1,
    ORIENT_CCW      = 2'd2,
    ORIENT_OVERFLOW = 2'd3
  } orient_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Three consecutive vertices i, j, k.
  typedef struct packed {
    point_t pi;
    point_t pj;
    point_t pk;
  } triple_t;

  typedef struct packed {
    logic last;
    logic ovf;
    logic short_poly;
  } ctl_t;

endpackage

>>> design/potc_track.sv
`timescale 1ns / 1ps
module potc_track (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         acc_i,
  input  logic                                         en_i,
  input  potc_pkg::point_t                             vtx_i,
  input  logic                                         last_i,
  output logic                                         valid_o,
  output potc_pkg::triple_t [potc_pkg::NUM_LANES-1:0] lane_o,
  output logic [potc_pkg::NUM_LANES-1:0]               lane_v_o,
  output potc_pkg::ctl_t                               ctl_o
);
  import potc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  point_t first_q, second_q, older_q, newer_q;
  logic turn_ok, wrap_ok, is_ovf, is_short;

  logic                          valid_q;
  triple_t [NUM_LANES-1:0]       lane_q;
  logic [NUM_LANES-1:0]          lane_v_q;
  ctl_t                          ctl_q;

  always_comb begin
    cnt_inc  = (cnt_q <= CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
    is_ovf   = cnt_inc > CNT_MAX;
    is_short = cnt_inc < CNT_W'(3);
    turn_ok  = (cnt_q >= CNT_W'(2)) && (cnt_q <= CNT_MAX - CNT_W'(1));
    wrap_ok  = last_i && !is_ovf && !is_short;
    cnt_d    = last_i ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Vertex history; only read once the count says it was written.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      if (cnt_q == '0) begin
        first_q <= vtx_i;
      end
      if (cnt_q == CNT_W'(1)) begin
        second_q <= vtx_i;
      end
      older_q <= newer_q;
      newer_q <= vtx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && acc_i) begin
      lane_q[0]      <= '{pi: older_q, pj: newer_q, pk: vtx_i};
      lane_q[1]      <= '{pi: newer_q, pj: vtx_i, pk: first_q};
      lane_q[2]      <= '{pi: vtx_i, pj: first_q, pk: second_q};
      lane_v_q       <= {wrap_ok, wrap_ok, turn_ok};
      ctl_q.last       <= last_i;
      ctl_q.ovf        <= last_i && is_ovf;
      ctl_q.short_poly <= last_i && is_short;
    end
  end

  assign valid_o  = valid_q;
  assign lane_o   = lane_q;
  assign lane_v_o = lane_v_q;
  assign ctl_o    = ctl_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX + CNT_W'(1))
    else $error("vertex count beyond saturation");

  a_wrap_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && lane_v_q[1]) |-> (ctl_q.last && lane_v_q[2]))
    else $error("wrap-around turns without final vertex");

endmodule

>>> design/potc_cross.sv
`timescale 1ns / 1ps
module potc_cross (
  input  logic              clk_i,
  input  logic              en_i,
  input  potc_pkg::triple_t trip_i,
  output potc_pkg::sign_t   sign_o
);
  import potc_pkg::*;

  logic signed [DIFF_W-1:0]  ex1, ey1, ex2, ey2;
  logic signed [PROD_W-1:0]  pa_q, pb_q;
  logic signed [CROSS_W-1:0] z;

  always_comb begin
    ex1 = $signed({trip_i.pj.x[COORD_W-1], trip_i.pj.x})
        - $signed({trip_i.pi.x[COORD_W-1], trip_i.pi.x});
    ey1 = $signed({trip_i.pj.y[COORD_W-1], trip_i.pj.y})
        - $signed({trip_i.pi.y[COORD_W-1], trip_i.pi.y});
    ex2 = $signed({trip_i.pk.x[COORD_W-1], trip_i.pk.x})
        - $signed({trip_i.pj.x[COORD_W-1], trip_i.pj.x});
    ey2 = $signed({trip_i.pk.y[COORD_W-1], trip_i.pk.y})
        - $signed({trip_i.pj.y[COORD_W-1], trip_i.pj.y});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= ex1 * ey2;
      pb_q <= ey1 * ex2;
    end
  end

  always_comb begin
    z = $signed({pa_q[PROD_W-1], pa_q}) - $signed({pb_q[PROD_W-1], pb_q});
    if (z[CROSS_W-1]) begin
      sign_o = SIGN_NEG;
    end else if (z == '0) begin
      sign_o = SIGN_ZERO;
    end else begin
      sign_o = SIGN_POS;
    end
  end

endmodule

>>> design/potc_tally.sv
`timescale 1ns / 1ps
module potc_tally (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  potc_pkg::ctl_t                            ctl_i,
  input  logic [potc_pkg::NUM_LANES-1:0]            lane_v_i,
  input  potc_pkg::sign_t [potc_pkg::NUM_LANES-1:0] sign_i,
  input  logic                                      out_ready_i,
  output logic                                      en_o,
  output logic                                      out_valid_o,
  output potc_pkg::orient_e                         orient_o
);
  import potc_pkg::*;

  localparam logic signed [BAL_W-1:0] BAL_LIM  = BAL_W'(MAX_VERTICES);
  localparam logic signed [BAL_W-1:0] BAL_ZERO = '0;

  logic                      v2_q;
  ctl_t                      ctl2_q;
  logic [NUM_LANES-1:0]      lane_v2_q;
  logic signed [BAL_W-1:0]   bal_q, bal_d, delta;
  logic                      adv, fire;
  logic                      out_v_q;
  orient_e                   out_q, code;

  assign adv  = !out_v_q || out_ready_i;
  assign en_o = !v2_q || adv;
  assign fire = v2_q && adv;

  always_comb begin
    delta = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (lane_v2_q[k]) begin
        delta = delta + BAL_W'(sign_i[k]);
      end
    end
    bal_d = bal_q + delta;
    priority if (ctl2_q.ovf) begin
      code = ORIENT_OVERFLOW;
    end else if (ctl2_q.short_poly) begin
      code = ORIENT_DEGEN;
    end else if (bal_d > BAL_ZERO) begin
      code = ORIENT_CCW;
    end else if (bal_d < BAL_ZERO) begin
      code = ORIENT_CW;
    end else begin
      code = ORIENT_DEGEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q    <= 1'b0;
      bal_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en_o) begin
        v2_q <= valid_i;
      end
      if (fire) begin
        bal_q <= ctl2_q.last ? '0 : bal_d;
      end
      if (adv) begin
        out_v_q <= fire && ctl2_q.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      ctl2_q    <= ctl_i;
      lane_v2_q <= lane_v_i;
    end
    if (adv) begin
      out_q <= code;
    end
  end

  assign out_valid_o = out_v_q;
  assign orient_o    = out_q;

  a_bal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bal_q <= BAL_LIM) && (bal_q >= -BAL_LIM))
    else $error("turn balance out of range");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> !(ctl2_q.ovf && ctl2_q.short_poly))
    else $error("overflow and short polygon both flagged");

  a_ovf_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctl2_q.last && ctl2_q.ovf) |=> (out_v_q && out_q == ORIENT_OVERFLOW))
    else $error("overflow polygon not reported");

  a_bal_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctl2_q.last) |=> (bal_q == '0))
    else $error("balance not cleared after polygon");

endmodule

>>> design/polygon_orientation_turn_count.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields (tdata from bit 0 up)         Transfer when
// s_axis   in   tdata: x[23:0], y[47:24]; tlast     tvalid && tready
// m_axis   out  tdata: orientation[1:0], zero pad  tvalid && tready
//
// One vertex per cycle sustained while the output is not stalled; after its final
// vertex transfer a result passes the history/lane, product and result registers.
// The rate is set by the three cross-product lanes, each two 25x25 multipliers.
// Reset clears the vertex count, pipeline valid bits and the turn balance.
// A stalled result holds the pipeline stage by stage; input stays open while
// any stage ahead of the result register is empty.
module polygon_orientation_turn_count (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x[23:0], y[47:24]
  input  logic [potc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // orientation[1:0], zeros above
  output logic [potc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import potc_pkg::*;

  point_t                  vtx;
  logic                    acc, en1, en2, v1;
  triple_t [NUM_LANES-1:0] lane;
  logic [NUM_LANES-1:0]    lane_v;
  ctl_t                    ctl1;
  sign_t [NUM_LANES-1:0]   sign;
  orient_e                 orient;

  // Unpack the vertex from the transfer.
  assign vtx.x = s_axis_tdata[COORD_W-1:0];
  assign vtx.y = s_axis_tdata[2*COORD_W-1:COORD_W];

  // Advance the front stage when it is empty or its item moves on.
  assign en1           = !v1 || en2;
  assign s_axis_tready = en1;
  assign acc           = s_axis_tvalid && en1;

  // Vertex history, counting and lane setup.
  potc_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .en_i     (en1),
    .vtx_i    (vtx),
    .last_i   (s_axis_tlast),
    .valid_o  (v1),
    .lane_o   (lane),
    .lane_v_o (lane_v),
    .ctl_o    (ctl1)
  );

  // One cross-product unit per turn: the running triple and both wrap-arounds.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    potc_cross u_cross (
      .clk_i  (clk_i),
      .en_i   (en2),
      .trip_i (lane[g]),
      .sign_o (sign[g])
    );
  end

  // Accumulate turn signs and hold the result for the output transfer.
  potc_tally u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1),
    .ctl_i       (ctl1),
    .lane_v_i    (lane_v),
    .sign_i      (sign),
    .out_ready_i (m_axis_tready),
    .en_o        (en2),
    .out_valid_o (m_axis_tvalid),
    .orient_o    (orient)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - 2){1'b0}}, orient};

endmodule
